// File: hdl/itoar_pkg.sv
// Shared constants, types and the radix divider step for the integer to ASCII converter.
// No dependencies.
package itoar_pkg;

  localparam int RADIX_W     = 5;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int NIB_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 5'd10;

  localparam logic [ADDR_W-3:0] REG_RADIX = 1'b0;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [7:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic               sign;
    logic [RADIX_W-1:0] radix;
  } item_ctrl_t;

  typedef struct packed {
    logic [NIB_W-1:0] rem;
    logic [NIB_W-1:0] quo;
  } step_t;

  // Four restoring division steps on a remainder that stays below the radix.
  function automatic step_t div_step(input logic [NIB_W-1:0]   rem_in,
                                     input logic [NIB_W-1:0]   nib,
                                     input logic [RADIX_W-1:0] radix);
    step_t              r;
    logic [RADIX_W-1:0] t;
    r     = '0;
    r.rem = rem_in;
    for (int k = NIB_W - 1; k >= 0; k--) begin
      t = {r.rem, nib[k]};
      if (t >= radix) begin
        r.quo[k] = 1'b1;
        t        = t - radix;
      end else begin
        r.quo[k] = 1'b0;
      end
      r.rem = t[NIB_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/itoar_front.sv
// Front stage: accepts a signed value, forms its magnitude and decides on a sign character.
// Depends on itoar_pkg.
module itoar_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_WIDTH-1:0]   value,
  input  logic [itoar_pkg::RADIX_W-1:0]   radix,
  output logic                            push_valid,
  input  logic                            push_stall,
  output itoar_pkg::item_ctrl_t           push_ctrl,
  output logic [VALUE_WIDTH-1:0]          push_mag
);
  import itoar_pkg::*;

  logic                   f_valid;
  item_ctrl_t             f_ctrl;
  logic [VALUE_WIDTH-1:0] f_mag;
  logic [VALUE_WIDTH-1:0] value_u;
  logic                   accept;

  assign value_u    = unsigned'(value);
  assign in_stall   = f_valid && push_stall;
  assign accept     = in_valid && !in_stall;
  assign push_valid = f_valid;
  assign push_ctrl  = f_ctrl;
  assign push_mag   = f_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!push_stall) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_ctrl.sign  <= value_u[VALUE_WIDTH-1] && (radix == RADIX_DECIMAL);
      f_ctrl.radix <= radix;
      f_mag        <= value_u[VALUE_WIDTH-1] ?
                      (~value_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_u;
    end
  end

endmodule

// File: hdl/itoar_queue.sv
// Two-entry request queue between the front stage and the conversion engine.
// Depends on itoar_pkg.
module itoar_queue #(
  parameter int WIDTH = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output logic [WIDTH-1:0] rd_data
);
  import itoar_pkg::*;

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign wr_stall = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: hdl/itoar_back.sv
// Conversion engine: divides the magnitude by the radix one digit at a time, stacks the
// digits and sends the characters most significant first. Depends on itoar_pkg.
module itoar_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_stall,
  input  itoar_pkg::item_ctrl_t  q_ctrl,
  input  logic [VALUE_WIDTH-1:0] q_mag,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             character,
  output logic                   last
);
  import itoar_pkg::*;

  localparam int NCH   = (VALUE_WIDTH + NIB_W - 1) / NIB_W;
  localparam int PAD_W = NCH * NIB_W;
  localparam int CNT_W = $clog2(NCH);
  localparam int ND_W  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t           state;
  item_ctrl_t       ctrl;
  logic [PAD_W-1:0] work;
  logic [PAD_W-1:0] work_next;
  logic [NIB_W-1:0] rem;
  logic [CNT_W-1:0] chunk;
  logic [NIB_W-1:0] digits [VALUE_WIDTH];
  logic [ND_W-1:0]  nd;
  logic             sign_pend;
  logic             out_free;
  step_t            step;

  assign q_stall   = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign step      = div_step(rem, work[PAD_W-1 -: NIB_W], ctrl.radix);
  assign work_next = {work[PAD_W-NIB_W-1:0], step.quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sign_pend <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ctrl      <= q_ctrl;
            work      <= PAD_W'(q_mag);
            rem       <= '0;
            chunk     <= '0;
            nd        <= '0;
            sign_pend <= q_ctrl.sign;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          work <= work_next;
          if (chunk == CNT_W'(NCH - 1)) begin
            digits[0] <= step.rem;
            for (int i = 1; i < VALUE_WIDTH; i++) begin
              digits[i] <= digits[i-1];
            end
            nd    <= nd + 1'b1;
            rem   <= '0;
            chunk <= '0;
            if (work_next == '0) begin
              state <= S_EMIT;
            end
          end else begin
            rem   <= step.rem;
            chunk <= chunk + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (sign_pend) begin
              character <= CHAR_MINUS;
              last      <= 1'b0;
              sign_pend <= 1'b0;
            end else begin
              character <= DIGIT_CHARS[digits[0]];
              last      <= (nd == ND_W'(1));
              for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                digits[i] <= digits[i+1];
              end
              nd <= nd - 1'b1;
              if (nd == ND_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < ctrl.radix))
    else $error("division remainder reached the radix");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == CHAR_MINUS) |-> !last)
    else $error("sign character marked as final character");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (nd != '0 && nd <= ND_W'(VALUE_WIDTH)))
    else $error("emitting with a bad digit count");

  a_sign_only_decimal: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && sign_pend) |-> (ctrl.radix == RADIX_DECIMAL))
    else $error("sign pending outside radix ten");

endmodule

// File: hdl/integer_to_ascii_radix.sv
// Integer to ASCII converter in a programmable radix: APB radix register, front stage,
// request queue and conversion engine. Depends on itoar_pkg, itoar_front, itoar_queue, itoar_back.
//
// Each request carries one signed value and produces its text in the radix held in the
// register at byte address 0 (2 to 16, resets to 10, the low five bits of a written value
// saturate into range), one character per output transfer, most significant first, with
// last on the final one. Only radix ten prints a minus sign; other radixes print the
// magnitude. The front stage and a two-entry queue take new requests while the engine
// works. The engine picks up a request, then works out each digit in its shared divider,
// which retires four quotient bits per cycle, then moves the characters into the output
// register one at a time, holding while the receiver stalls.
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [itoar_pkg::ADDR_W-1:0]   paddr,
  input  logic [itoar_pkg::DATA_W-1:0]   pwdata,
  output logic [itoar_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [VALUE_WIDTH-1:0]  value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     character,
  output logic                           last
);
  import itoar_pkg::*;

  localparam int QW = $bits(item_ctrl_t) + VALUE_WIDTH;

  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     wr_radix;
  logic                   reg_hit;
  logic                   push_valid;
  logic                   push_stall;
  item_ctrl_t             push_ctrl;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   pop_valid;
  logic                   pop_stall;
  logic [QW-1:0]          pop_data;
  item_ctrl_t             pop_ctrl;
  logic [VALUE_WIDTH-1:0] pop_mag;

  assign pready   = 1'b1;
  assign reg_hit  = (paddr[ADDR_W-1:2] == REG_RADIX);
  assign wr_radix = pwdata[RADIX_W-1:0];
  assign prdata   = reg_hit ? {{(DATA_W-RADIX_W){1'b0}}, radix} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      if (wr_radix < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (wr_radix > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= wr_radix;
      end
    end
  end

  itoar_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .radix      (radix),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_ctrl  (push_ctrl),
    .push_mag   (push_mag)
  );

  itoar_queue #(.WIDTH(QW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_stall (push_stall),
    .wr_data  ({push_ctrl, push_mag}),
    .rd_valid (pop_valid),
    .rd_stall (pop_stall),
    .rd_data  (pop_data)
  );

  assign pop_ctrl = pop_data[QW-1:VALUE_WIDTH];
  assign pop_mag  = pop_data[VALUE_WIDTH-1:0];

  itoar_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_stall   (pop_stall),
    .q_ctrl    (pop_ctrl),
    .q_mag     (pop_mag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

// File: dv/integer_to_ascii_radix_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_ascii_radix: directed and random requests,
// radix register writes over APB, and a character predictor. Depends on itoar_pkg and integer_to_ascii_radix.
module integer_to_ascii_radix_test;
  import itoar_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 320;
  localparam int HOLD_CYCLES = 400;
  localparam int TEXT_LEN = 12;
  localparam int NUM_ROWS = 24;
  localparam int REPORT_LIMIT = 10;
  localparam longint TIMEOUT_NS = 5_000_000;
  localparam logic [ADDR_W-1:0] ADDR_RADIX = {REG_RADIX, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam logic [7:0] ASCII_ZERO = "0";
  localparam logic [7:0] ASCII_A = "A";

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } glyph_t;

  typedef struct packed {
    logic                  wr;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     data;
    logic [31:0]           val;
    logic [8*TEXT_LEN-1:0] text;
  } row_t;

  // A zero text means the expected characters come from the predictor.
  row_t script [NUM_ROWS] = '{
    '{1'b0, ADDR_RADIX,  32'd0,          32'd0,          "0"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'd1,          "1"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'hFFFF_FFFF,  "-1"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h7FFF_FFFF,  "2147483647"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h8000_0000,  "-2147483648"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'd1234567890, "1234567890"},
    '{1'b1, ADDR_RADIX,  32'd16,         32'hFFFF_FFFF,  "1"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h7FFF_FFFF,  "7FFFFFFF"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h8000_0000,  "80000000"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h89AB_CDEF,  "76543211"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h00AB_CDEF,  "ABCDEF"},
    '{1'b1, ADDR_RADIX,  32'd0,          32'd5,          "101"},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h8000_0000,  '0},
    '{1'b0, ADDR_RADIX,  32'd0,          32'h7FFF_FFFF,  '0},
    '{1'b1, ADDR_UNUSED, 32'd3,          32'd6,          "110"},
    '{1'b1, ADDR_RADIX,  32'd1,          32'hFFFF_FFFB,  "101"},
    '{1'b1, ADDR_RADIX,  32'd31,         32'd255,        "FF"},
    '{1'b1, ADDR_RADIX,  32'd17,         32'hFFFF_FF00,  "100"},
    '{1'b1, ADDR_RADIX,  32'hFFFF_FFE3,  32'd8,          "22"},
    '{1'b1, ADDR_RADIX,  32'd32,         32'd2,          "10"},
    '{1'b1, ADDR_RADIX,  32'd7,          32'hFFFF_FFCF,  "100"},
    '{1'b1, ADDR_RADIX,  32'd36,         32'd0,          "0"},
    '{1'b1, ADDR_RADIX,  32'd9,          32'h8000_0000,  '0},
    '{1'b1, ADDR_RADIX,  32'd10,         32'hFFFF_FFF6,  "-10"}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] character;
  logic last;

  logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
  glyph_t pending_chars [$];
  int failures = 0;
  int values_sent = 0;
  int chars_checked = 0;
  int radix_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;

  integer_to_ascii_radix #(.VALUE_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .character(character), .last(last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  // Spells the value in the current radix and queues its characters.
  function automatic void spell_value(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] rem;
    logic [7:0]  digs [$];
    mag = v[31] ? (~v + 32'd1) : v;
    do begin
      rem = mag % radix_shadow;
      digs.push_back(rem < 10 ? ASCII_ZERO + rem[7:0] : ASCII_A + rem[7:0] - 8'd10);
      mag = mag / radix_shadow;
    end while (mag != 0);
    if (v[31] && radix_shadow == RADIX_DECIMAL) pending_chars.push_back('{CHAR_MINUS, 1'b0});
    for (int i = digs.size() - 1; i >= 0; i--) pending_chars.push_back('{digs[i], i == 0});
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] p;
    int k;
    case ($urandom_range(4))
      0: begin
        v = $urandom_range(40);
        if ($urandom_range(1)) v = -v;
      end
      1: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'd1;
          default: v = 32'd0;
        endcase
      end
      2: begin
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p <= 32'h7FFF_FFFF / radix_shadow) begin
          p = p * radix_shadow;
          k--;
        end
        v = p + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_radix_data();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(31);
      2: begin
        case ($urandom_range(5))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'd2;
          3: return 32'd16;
          4: return 32'd17;
          default: return 32'd31;
        endcase
      end
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  task automatic settle();
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes a register, then reads the radix back in a second transfer.
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [RADIX_W-1:0] r;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_RADIX) begin
      r = data[RADIX_W-1:0];
      if (r < RADIX_MIN) r = RADIX_MIN;
      else if (r > RADIX_MAX) r = RADIX_MAX;
      radix_shadow = r;
    end
    radix_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_RADIX;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== DATA_W'(radix_shadow))
      note_failure($sformatf("radix readback expected %0d got %0d", radix_shadow, prdata));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one request; valid stays high at acceptance when another request follows at once.
  task automatic offer_value(input logic [31:0] v, input bit more,
                             input logic [8*TEXT_LEN-1:0] text);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    values_sent++;
    if (text == '0) begin
      spell_value(v);
    end else begin
      for (int b = TEXT_LEN - 1; b >= 0; b--)
        if (text[8*b +: 8] != 8'h00) pending_chars.push_back('{text[8*b +: 8], b == 0});
    end
    if (!more) in_valid <= 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    glyph_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("unexpected character %h last %b", character, last));
      end else begin
        want = pending_chars.pop_front();
        if (want.ch !== character || want.lst !== last)
          note_failure($sformatf("expected character %h last %b, got %h last %b",
                                 want.ch, want.lst, character, last));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d characters outstanding", pending_chars.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit more;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 33;
    recv_stall_pct = 65;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (script[i].wr) begin
        settle();
        write_register(script[i].addr, script[i].data);
      end
      more = (i + 1 < NUM_ROWS) ? !script[(i + 1) % NUM_ROWS].wr : 1'b0;
      offer_value(script[i].val, more, script[i].text);
    end

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 33 : (p == 1) ? 65 : 0;
      recv_stall_pct = (p == 0) ? 65 : (p == 1) ? 33 : 0;
      for (int s = 0; s < 4; s++) begin
        settle();
        write_register(ADDR_RADIX, pick_radix_data());
        if (p == 0 && s == 1) holds_asked++;
        for (int k = 0; k < 8; k++) offer_value(pick_value(), k < 7, '0);
      end
    end

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d values (%0d from the directed table) into %0d characters,",
             values_sent, NUM_ROWS, chars_checked);
    $display("with %0d register writes, one long output hold and %0d failures.",
             radix_writes, failures);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
